/* sv/dq_pkg.sv */
// Shared constants and types of the double-ended queue.
`default_nettype none
package dq_pkg;

	localparam int DATA_W       = 32;
	localparam int CMD_W        = 3;
	localparam int CAPACITY_DEF = 64;

	localparam logic [CMD_W-1:0] CMD_PUSH_LEFT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_RIGHT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_LEFT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_RIGHT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_NOP        = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] left_value;
		logic signed [DATA_W-1:0] right_value;
		logic                     is_empty;
		logic                     is_full;
		logic                     op_error;
	} rsp_t;

endpackage
`default_nettype wire

/* sv/dq_cmd_if.sv */
// Command channel: valid/ready handshake carrying one deque command item.
`default_nettype none
interface dq_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [dq_pkg::CMD_W-1:0]         command;
	logic signed [dq_pkg::DATA_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

/* sv/dq_res_if.sv */
// Result channel: valid/ready handshake carrying the deque status after each item.
`default_nettype none
interface dq_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [dq_pkg::DATA_W-1:0] left_value;
	logic signed [dq_pkg::DATA_W-1:0] right_value;
	logic                             is_empty;
	logic                             is_full;
	logic                             op_error;

	modport source (output valid, output left_value, output right_value, output is_empty,
		output is_full, output op_error, input ready);
	modport sink   (input valid, input left_value, input right_value, input is_empty,
		input is_full, input op_error, output ready);
endinterface
`default_nettype wire

/* sv/dq_store.sv */
// Element store: synchronous memory, one write port and two registered read ports.
`default_nettype none
module dq_store #(
	parameter int DEPTH = dq_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(dq_pkg::CAPACITY_DEF)
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [dq_pkg::DATA_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [AW-1:0]             raddr_l,
	input  wire logic [AW-1:0]             raddr_r,
	output logic      [dq_pkg::DATA_W-1:0] rdata_l,
	output logic      [dq_pkg::DATA_W-1:0] rdata_r
);

	logic [dq_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [dq_pkg::DATA_W-1:0] rd_l_q;
	logic [dq_pkg::DATA_W-1:0] rd_r_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_l_q <= mem_q[raddr_l];
			rd_r_q <= mem_q[raddr_r];
		end
	end

	assign rdata_l = rd_l_q;
	assign rdata_r = rd_r_q;

endmodule
`default_nettype wire

/* sv/dq_ctrl.sv */
// Deque control: end pointer and count update, store writes, end reads, response build.
`default_nettype none
module dq_ctrl #(
	parameter int CAPACITY = dq_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(dq_pkg::CAPACITY_DEF)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	dq_cmd_if.sink                         cmd,
	output logic                           mem_we,
	output logic      [AW-1:0]             mem_waddr,
	output logic      [dq_pkg::DATA_W-1:0] mem_wdata,
	output logic                           mem_re,
	output logic      [AW-1:0]             mem_raddr_l,
	output logic      [AW-1:0]             mem_raddr_r,
	input  wire logic [dq_pkg::DATA_W-1:0] mem_rdata_l,
	input  wire logic [dq_pkg::DATA_W-1:0] mem_rdata_r,
	output logic                           rsp_valid,
	output dq_pkg::rsp_t                   rsp,
	input  wire logic                      rsp_ready
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST_C = AW'(CAPACITY - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_XFER = 3'b100
	} state_t;

	state_t         state_q, state_d;
	logic [AW-1:0]  left_q, left_d;
	logic [CW-1:0]  count_q, count_d;
	logic           err_q, err_d;
	logic           we_c;
	logic [AW-1:0]  waddr_c;
	logic           accept;
	logic           full, empty;

	// position off places right of base, wrapped at the capacity
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= SW'(CAPACITY)) begin
			s = s - SW'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	assign full   = (count_q == CAP_C);
	assign empty  = (count_q == '0);
	assign accept = cmd.valid && cmd.ready;

	always_comb begin
		left_d  = left_q;
		count_d = count_q;
		err_d   = 1'b0;
		we_c    = 1'b0;
		waddr_c = left_q;
		case (cmd.command)
			dq_pkg::CMD_PUSH_LEFT: begin
				if (full) begin
					err_d = 1'b1;
				end else begin
					left_d  = (left_q == '0) ? LAST_C : left_q - 1'b1;
					we_c    = 1'b1;
					waddr_c = left_d;
					count_d = count_q + 1'b1;
				end
			end
			dq_pkg::CMD_PUSH_RIGHT: begin
				if (full) begin
					err_d = 1'b1;
				end else begin
					we_c    = 1'b1;
					waddr_c = slot(left_q, count_q);
					count_d = count_q + 1'b1;
				end
			end
			dq_pkg::CMD_POP_LEFT: begin
				if (empty) begin
					err_d = 1'b1;
				end else begin
					left_d  = slot(left_q, CW'(1));
					count_d = count_q - 1'b1;
				end
			end
			dq_pkg::CMD_POP_RIGHT: begin
				if (empty) begin
					err_d = 1'b1;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				// no operation, unused codes included
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_XFER;
			end
			ST_XFER: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
			count_q <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				left_q  <= left_d;
				count_q <= count_d;
				err_q   <= err_d;
			end
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);

	assign mem_we    = accept && we_c;
	assign mem_waddr = waddr_c;
	assign mem_wdata = cmd.value;

	// ends are read the cycle after the update, so the write has already landed
	assign mem_re      = (state_q == ST_READ);
	assign mem_raddr_l = left_q;
	assign mem_raddr_r = slot(left_q, empty ? '0 : count_q - 1'b1);

	assign rsp_valid        = (state_q == ST_XFER);
	assign rsp.left_value   = empty ? '0 : mem_rdata_l;
	assign rsp.right_value  = empty ? '0 : mem_rdata_r;
	assign rsp.is_empty     = empty;
	assign rsp.is_full      = full;
	assign rsp.op_error     = err_q;

endmodule
`default_nettype wire

/* sv/double_ended_queue.sv */
// Top level of the bounded double-ended queue.
// Bounded deque of signed 32-bit values held in a circular buffer of CAPACITY entries.
// Each command item (push left, push right, pop left, pop right, no operation) yields one
// result item with the leftmost and rightmost values (zero when empty), the empty and full
// flags and an error flag for a refused push on full or pop on empty; a refused command
// changes nothing. Each item goes through these steps: accept and update of the pointer,
// count and memory write, then a read of both ends from the synchronous element memory,
// then the move into the result register once it is free. The result register lets the
// next command be accepted while an earlier result still waits to be taken.
`default_nettype none
module double_ended_queue #(
	parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dq_cmd_if.sink    cmd,
	dq_res_if.source  res
);

	localparam int AW = $clog2(CAPACITY);

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [dq_pkg::DATA_W-1:0] mem_wdata;
	logic                      mem_re;
	logic [AW-1:0]             mem_raddr_l;
	logic [AW-1:0]             mem_raddr_r;
	logic [dq_pkg::DATA_W-1:0] mem_rdata_l;
	logic [dq_pkg::DATA_W-1:0] mem_rdata_r;
	logic                      rsp_valid;
	logic                      rsp_ready;
	dq_pkg::rsp_t              rsp;

	dq_pkg::rsp_t              res_q;
	logic                      res_valid_q;

	dq_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr_l (mem_raddr_l),
		.mem_raddr_r (mem_raddr_r),
		.mem_rdata_l (mem_rdata_l),
		.mem_rdata_r (mem_rdata_r),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp),
		.rsp_ready   (rsp_ready)
	);

	dq_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_l (mem_raddr_l),
		.raddr_r (mem_raddr_r),
		.rdata_l (mem_rdata_l),
		.rdata_r (mem_rdata_r)
	);

	// result register: free when empty or being taken this cycle
	assign rsp_ready = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			res_valid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ready && rsp_valid) begin
			res_q <= rsp;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.left_value  = res_q.left_value;
	assign res.right_value = res_q.right_value;
	assign res.is_empty    = res_q.is_empty;
	assign res.is_full     = res_q.is_full;
	assign res.op_error    = res_q.op_error;

endmodule
`default_nettype wire
